### rtl/mbwrc_pkg.sv
package mbwrc_pkg;

    // Frame layout
    localparam int          FrameLen        = 9;
    localparam logic [3:0]  POS_ADDR        = 4'd0;
    localparam logic [3:0]  POS_FUNC        = 4'd1;
    localparam logic [3:0]  POS_RAW_HI      = 4'd3;
    localparam logic [3:0]  POS_RAW_LO      = 4'd4;
    localparam logic [3:0]  POS_DP          = 4'd6;
    localparam logic [3:0]  POS_LAST        = 4'(FrameLen - 1);

    localparam logic [7:0]  FUNC_READ_HOLDING = 8'h03;
    localparam logic [7:0]  SLAVE_ADDR_RESET  = 8'h01;

    // Modbus CRC-16, reflected
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    // Input modes
    localparam logic MODE_BYTE    = 1'b0;
    localparam logic MODE_TIMEOUT = 1'b1;

    // Result status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_TIMEOUT = 2'd1;
    localparam logic [1:0] ST_HEADER  = 2'd2;
    localparam logic [1:0] ST_CRC     = 2'd3;

    // Decimal point codes
    localparam logic [7:0] DP_TENTHS      = 8'd1;
    localparam logic [7:0] DP_HUNDREDTHS  = 8'd2;
    localparam logic [7:0] DP_THOUSANDTHS = 8'd3;

    // Reciprocals ceil(2^42 / d); exact floor division for dividends below 2^32
    localparam int          RecipShift = 42;
    localparam int          RecipW     = 39;
    localparam int          MagW       = 16;
    localparam int          ProdW      = MagW + RecipShift;
    localparam logic [RecipW-1:0] RECIP_10   = 39'd439804651111;
    localparam logic [RecipW-1:0] RECIP_100  = 39'd43980465112;
    localparam logic [RecipW-1:0] RECIP_1000 = 39'd4398046512;

    typedef struct packed {
        logic       mode;
        logic [7:0] rx_byte;
    } t_in;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [15:0] reading;
        logic [7:0]         point_code;
        logic signed [31:0] weight_q16;
    } t_out;

    function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

### rtl/modbus_weight_response_checker_core.sv
// Checks a 9-byte Modbus RTU read-holding-registers response (two registers) from a
// load-cell transmitter and delivers one result per complete frame or per timeout.
// Bytes are taken one per clock with no gaps needed; the CRC-16 is updated a whole
// byte per cycle. A result passes stage 1, stage 2 and the output register after the
// last CRC byte or the timeout is taken; the extra stages hold the reciprocal
// multiply that scales the measurement by 1, 10, 100 or 1000 into signed Q15.16
// (truncated toward zero). Results queue in the stages, so input only stalls when
// all three result stages are full. Statuses: ok, timeout, wrong address/function
// (wins over a CRC fault), CRC mismatch; all data fields read zero unless ok.
// The byte-count field only feeds the CRC. slave_address is written through the
// config channel, which is always ready; write it only while idle.
module modbus_weight_response_checker_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // byte / timeout input
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  mbwrc_pkg::t_in      i_in,
    // results
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output mbwrc_pkg::t_out     o_out,
    // slave address register
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [7:0]          i_cfg_data
);
    import mbwrc_pkg::*;

    // --- config -----------------------------------------------------------
    logic [7:0]  r_slave_addr;

    // --- frame state ------------------------------------------------------
    logic [3:0]  r_pos;
    logic [15:0] r_crc;
    logic        r_hdr_bad;
    logic [7:0]  r_raw_hi, r_raw_lo, r_dp;   // payload bytes that are used

    // --- result stage 1: status, magnitude, reciprocal select ------------
    logic              r_s1_valid;
    logic [1:0]        r_s1_status;
    logic [15:0]       r_s1_raw;
    logic [7:0]        r_s1_dp;
    logic              r_s1_neg;
    logic              r_s1_unit;
    logic [MagW-1:0]   r_s1_mag;
    logic [RecipW-1:0] r_s1_recip;

    // --- result stage 2: product -------------------------------------------
    logic              r_s2_valid;
    logic [1:0]        r_s2_status;
    logic [15:0]       r_s2_raw;
    logic [7:0]        r_s2_dp;
    logic              r_s2_neg;
    logic [ProdW-1:0]  r_s2_prod;

    // --- output register ---------------------------------------------------
    logic              r_out_valid;
    t_out              r_out;

    // handshake / flow
    logic in_acc, out_free, s2_free, s1_free, is_last, produce;
    logic [15:0] crc_next;

    // stage 1 next values
    logic [1:0]        n_s1_status;
    logic [15:0]       n_s1_raw;
    logic [7:0]        n_s1_dp;
    logic              n_s1_neg;
    logic              n_s1_unit;
    logic [MagW-1:0]   n_s1_mag;
    logic [RecipW-1:0] n_s1_recip;

    // stage 2 / out next values
    logic [MagW+RecipW-1:0] w_prod;
    logic [ProdW-1:0]       n_s2_prod;
    logic [31:0]            w_quot;
    logic [31:0]            n_weight;

    // Bubble-collapsing flow: a stage loads when empty or when its content moves on.
    assign out_free   = !r_out_valid || !i_out_stall;
    assign s2_free    = !r_s2_valid || out_free;
    assign s1_free    = !r_s1_valid || s2_free;
    assign o_in_stall = !s1_free;
    assign in_acc     = i_in_valid && s1_free;

    assign o_cfg_ready = 1'b1;

    assign crc_next = crc_feed(r_crc, i_in.rx_byte);
    assign is_last  = (r_pos == POS_LAST);
    assign produce  = (i_in.mode == MODE_TIMEOUT) || is_last;

    // Result assembly at frame end (or timeout). Header fault beats CRC fault.
    always_comb begin
        n_s1_status = ST_OK;
        n_s1_raw    = 16'd0;
        n_s1_dp     = 8'd0;
        n_s1_neg    = 1'b0;
        n_s1_unit   = 1'b1;
        n_s1_mag    = '0;
        n_s1_recip  = RECIP_10;
        if (i_in.mode == MODE_TIMEOUT) begin
            n_s1_status = ST_TIMEOUT;
        end else if (r_hdr_bad) begin
            n_s1_status = ST_HEADER;
        end else if (crc_next != 16'd0) begin
            n_s1_status = ST_CRC;
        end else begin
            n_s1_raw  = {r_raw_hi, r_raw_lo};
            n_s1_dp   = r_dp;
            n_s1_neg  = r_raw_hi[7];
            // two's complement magnitude; -32768 gives 32768, still fits unsigned
            n_s1_mag  = r_raw_hi[7] ? MagW'(~{r_raw_hi, r_raw_lo} + 16'd1)
                                    : MagW'({r_raw_hi, r_raw_lo});
            case (r_dp)
                DP_TENTHS: begin
                    n_s1_unit  = 1'b0;
                    n_s1_recip = RECIP_10;
                end
                DP_HUNDREDTHS: begin
                    n_s1_unit  = 1'b0;
                    n_s1_recip = RECIP_100;
                end
                DP_THOUSANDTHS: begin
                    n_s1_unit  = 1'b0;
                    n_s1_recip = RECIP_1000;
                end
                default: begin
                    n_s1_unit  = 1'b1;   // divisor 1
                    n_s1_recip = RECIP_10;
                end
            endcase
        end
    end

    // |raw| * 2^16 / d == (|raw| * ceil(2^42/d)) >> 26
    assign w_prod    = (MagW+RecipW)'(r_s1_mag) * (MagW+RecipW)'(r_s1_recip);
    assign n_s2_prod = r_s1_unit ? {r_s1_mag, {RecipShift{1'b0}}} : ProdW'(w_prod);

    assign w_quot   = r_s2_prod[ProdW-1 -: 32];
    assign n_weight = r_s2_neg ? (~w_quot + 32'd1) : w_quot;

    // Frame state and config
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slave_addr <= SLAVE_ADDR_RESET;
            r_pos        <= POS_ADDR;
            r_crc        <= CRC_INIT;
            r_hdr_bad    <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_slave_addr <= i_cfg_data;
            end
            if (in_acc) begin
                if (produce) begin
                    r_pos     <= POS_ADDR;
                    r_crc     <= CRC_INIT;
                    r_hdr_bad <= 1'b0;
                end else begin
                    r_pos <= r_pos + 4'd1;
                    r_crc <= crc_next;
                    if ((r_pos == POS_ADDR && i_in.rx_byte != r_slave_addr) ||
                        (r_pos == POS_FUNC && i_in.rx_byte != FUNC_READ_HOLDING)) begin
                        r_hdr_bad <= 1'b1;
                    end
                end
            end
        end
    end

    // Payload bytes: no reset, each written before it is read within a frame
    always_ff @(posedge i_clk) begin
        if (in_acc && i_in.mode == MODE_BYTE) begin
            if (r_pos == POS_RAW_HI) r_raw_hi <= i_in.rx_byte;
            if (r_pos == POS_RAW_LO) r_raw_lo <= i_in.rx_byte;
            if (r_pos == POS_DP)     r_dp     <= i_in.rx_byte;
        end
    end

    // Result pipeline control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s1_free)  r_s1_valid  <= in_acc && produce;
            if (s2_free)  r_s2_valid  <= r_s1_valid;
            if (out_free) r_out_valid <= r_s2_valid;
        end
    end

    // Result pipeline data
    always_ff @(posedge i_clk) begin
        if (s1_free && in_acc && produce) begin
            r_s1_status <= n_s1_status;
            r_s1_raw    <= n_s1_raw;
            r_s1_dp     <= n_s1_dp;
            r_s1_neg    <= n_s1_neg;
            r_s1_unit   <= n_s1_unit;
            r_s1_mag    <= n_s1_mag;
            r_s1_recip  <= n_s1_recip;
        end
        if (s2_free && r_s1_valid) begin
            r_s2_status <= r_s1_status;
            r_s2_raw    <= r_s1_raw;
            r_s2_dp     <= r_s1_dp;
            r_s2_neg    <= r_s1_neg;
            r_s2_prod   <= n_s2_prod;
        end
        if (out_free && r_s2_valid) begin
            r_out.status     <= r_s2_status;
            r_out.reading    <= r_s2_raw;
            r_out.point_code <= r_s2_dp;
            r_out.weight_q16 <= n_weight;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

### verif/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import mbwrc_pkg::*;

    // Stimulus sizing: about 200 random frames, most of them nine bytes long, spread over
    // several slave address settings.
    localparam int PhaseFrames  = 34;
    localparam int SettleCycles = 10;     // lets the result stages settle after the last byte
    localparam int DrainLimit   = 5000;   // cycles to wait for outstanding results

    logic        i_clk;
    logic        i_rst_n;

    logic        in_valid;
    logic        in_stall;
    t_in         in_item;

    logic        out_valid;
    logic        out_stall;
    t_out        out_item;

    logic        cfg_valid;
    logic        cfg_ready;
    logic [7:0]  cfg_data;

    modbus_weight_response_checker_core i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in        (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out       (out_item),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    // ------------------------------------------------------------------
    // Frame tracker: own copy of the slave address and the frame state.
    // ------------------------------------------------------------------
    logic [7:0]  addr_cfg;
    logic [3:0]  frame_pos;
    logic [15:0] frame_crc;
    logic        frame_hdr_bad;
    logic [7:0]  frame_data [4];

    t_in         rx_queue [$];        // bytes and timeouts still to be sent
    t_out        result_queue [$];    // expected results, oldest first

    int          fault_count;
    logic        in_busy;             // an item is on the input channel awaiting transfer
    int          in_gap;
    int          stall_left;
    int          quiet_left [2];      // remaining cycles of a no-idle stretch, per side

    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        repeat (8) begin
            if (c[0]) c = (c >> 1) ^ CRC_POLY;
            else      c = c >> 1;
        end
        return c;
    endfunction

    task automatic restart_frame();
        frame_pos     = POS_ADDR;
        frame_crc     = CRC_INIT;
        frame_hdr_bad = 1'b0;
    endtask

    // Advance the tracker by one transferred item; queue the result it causes.
    task automatic weigh_item(input t_in it);
        t_out               res;
        logic signed [15:0] raw;
        longint             divisor;
        longint             scaled;
        res = '0;
        if (it.mode == MODE_TIMEOUT) begin
            // partial frame dropped, timeout always reported
            restart_frame();
            res.status = ST_TIMEOUT;
            result_queue.push_back(res);
        end else begin
            frame_crc = crc16_byte(frame_crc, it.rx_byte);
            if (frame_pos == POS_ADDR && it.rx_byte != addr_cfg) frame_hdr_bad = 1'b1;
            if (frame_pos == POS_FUNC && it.rx_byte != FUNC_READ_HOLDING) frame_hdr_bad = 1'b1;
            if (frame_pos >= POS_RAW_HI && frame_pos <= POS_DP)
                frame_data[2'(frame_pos - POS_RAW_HI)] = it.rx_byte;
            if (frame_pos != POS_LAST) begin
                frame_pos = frame_pos + 4'd1;
            end else begin
                // header fault wins over a CRC fault; CRC over all nine bytes is zero
                if (frame_hdr_bad) begin
                    res.status = ST_HEADER;
                end else if (frame_crc != 16'h0000) begin
                    res.status = ST_CRC;
                end else begin
                    raw = {frame_data[0], frame_data[1]};
                    case (frame_data[3])
                        DP_TENTHS:      divisor = 10;
                        DP_HUNDREDTHS:  divisor = 100;
                        DP_THOUSANDTHS: divisor = 1000;
                        default:        divisor = 1;
                    endcase
                    // integer division truncates toward zero
                    scaled = (longint'(raw) * 65536) / divisor;
                    res.status     = ST_OK;
                    res.reading    = raw;
                    res.point_code = frame_data[3];
                    res.weight_q16 = scaled[31:0];
                end
                result_queue.push_back(res);
                restart_frame();
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    // Build a response frame and queue its first 'keep' bytes. crc_flip
    // corrupts the trailing CRC.
    task automatic push_frame(input logic [7:0] addr, input logic [7:0] func,
                              input logic [7:0] count, input logic [15:0] raw,
                              input logic [15:0] dp_reg, input logic [15:0] crc_flip,
                              input int keep);
        logic [7:0]  b [9];
        logic [15:0] crc;
        t_in         it;
        b[0] = addr;
        b[1] = func;
        b[2] = count;
        b[3] = raw[15:8];
        b[4] = raw[7:0];
        b[5] = dp_reg[15:8];
        b[6] = dp_reg[7:0];
        crc = CRC_INIT;
        for (int i = 0; i < 7; i++) crc = crc16_byte(crc, b[i]);
        crc  = crc ^ crc_flip;
        b[7] = crc[7:0];      // CRC low byte goes first
        b[8] = crc[15:8];
        for (int i = 0; i < keep; i++) begin
            it.mode    = MODE_BYTE;
            it.rx_byte = b[i];
            rx_queue.push_back(it);
        end
    endtask

    task automatic push_timeout();
        t_in it;
        it.mode    = MODE_TIMEOUT;
        it.rx_byte = 8'($urandom);    // ignored by the block
        rx_queue.push_back(it);
    endtask

    task automatic push_noise();
        t_in it;
        int  n;
        n = $urandom_range(1, 12);
        repeat (n) begin
            it.mode    = MODE_BYTE;
            it.rx_byte = 8'($urandom);
            rx_queue.push_back(it);
        end
    endtask

    // Mostly well-formed responses with random content; the rest are faults,
    // truncated frames, line noise and stray timeouts.
    task automatic random_frame();
        int          kind;
        int          sel;
        logic [7:0]  dp_code;
        logic [7:0]  dp_hi;
        logic [7:0]  count;
        logic [15:0] raw;
        logic [15:0] flip;
        kind    = $urandom_range(0, 99);
        sel     = $urandom_range(0, 9);
        raw     = (sel == 0) ? 16'h8000 : (sel == 1) ? 16'h7FFF : 16'($urandom);
        dp_code = ($urandom_range(0, 9) < 8) ? 8'($urandom_range(0, 3)) : 8'($urandom);
        dp_hi   = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'h00;
        count   = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'd4;
        flip    = 16'(1 << $urandom_range(0, 15));
        if (kind < 60) begin
            push_frame(addr_cfg, FUNC_READ_HOLDING, count, raw, {dp_hi, dp_code}, 16'h0, 9);
        end else if (kind < 70) begin
            push_frame(addr_cfg, FUNC_READ_HOLDING, count, raw, {dp_hi, dp_code}, flip, 9);
        end else if (kind < 77) begin
            push_frame(addr_cfg ^ 8'(1 << $urandom_range(0, 7)), FUNC_READ_HOLDING, count,
                       raw, {dp_hi, dp_code}, ($urandom_range(0, 1) == 0) ? flip : 16'h0, 9);
        end else if (kind < 84) begin
            push_frame(addr_cfg, FUNC_READ_HOLDING ^ 8'(1 << $urandom_range(0, 7)), count,
                       raw, {dp_hi, dp_code}, ($urandom_range(0, 1) == 0) ? flip : 16'h0, 9);
        end else if (kind < 90) begin
            push_frame(addr_cfg, FUNC_READ_HOLDING, count, raw, {dp_hi, dp_code}, 16'h0,
                       $urandom_range(1, 8));
            push_timeout();
        end else if (kind < 95) begin
            push_noise();
            push_timeout();
        end else begin
            push_timeout();
        end
    endtask

    // Mostly short gaps, a few long ones, and now and then a stretch with none.
    function automatic int pick_gap(input int side);
        int r;
        if (quiet_left[side] > 0) begin
            quiet_left[side]--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 2) begin
            quiet_left[side] = $urandom_range(20, 80);
            return 0;
        end
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic log_fault(input string what, input t_out exp, input t_out got);
        fault_count++;
        if (fault_count <= 10)
            $display("[%0t] %s: exp %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
                     $time, what,
                     exp.status, exp.reading, exp.point_code, exp.weight_q16,
                     got.status, got.reading, got.point_code, got.weight_q16);
    endtask

    // Register write; only issued once the block has gone quiet.
    task automatic cfg_write(input logic [7:0] value);
        @(negedge i_clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge i_clk);
        while (!cfg_ready) @(posedge i_clk);
        addr_cfg = value;
        @(negedge i_clk);
        cfg_valid <= 1'b0;
    endtask

    // Wait for every queued item to transfer and every expected result to arrive,
    // then let the pipeline settle.
    task automatic wait_idle();
        int waited;
        waited = 0;
        while (rx_queue.size() > 0 || in_busy) @(posedge i_clk);
        while (result_queue.size() > 0 && waited < DrainLimit) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (SettleCycles) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Input driver: presents the head of rx_queue on the falling edge and
    // holds it until the transfer.
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else if (!in_busy) begin
            if (in_gap > 0) begin
                in_gap--;
                in_valid <= 1'b0;
            end else if (rx_queue.size() > 0) begin
                in_valid <= 1'b1;
                in_item  <= rx_queue[0];
                in_busy  = 1'b1;
                in_gap   = pick_gap(0);
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // Input transfer: update the tracker with what the block has just taken.
    always @(posedge i_clk) begin
        if (i_rst_n && in_valid && !in_stall) begin
            weigh_item(in_item);
            void'(rx_queue.pop_front());
            in_busy = 1'b0;
        end
    end

    // Output back-pressure
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            stall_left--;
            out_stall <= 1'b1;
        end else begin
            out_stall  <= 1'b0;
            stall_left = pick_gap(1);
        end
    end

    // Result monitor: each transfer checked against the oldest expectation
    always @(posedge i_clk) begin
        t_out exp;
        if (i_rst_n && out_valid && !out_stall) begin
            if (result_queue.size() == 0) begin
                log_fault("unexpected result", '0, out_item);
            end else begin
                exp = result_queue.pop_front();
                if (out_item.status     !== exp.status     ||
                    out_item.reading    !== exp.reading    ||
                    out_item.point_code !== exp.point_code ||
                    out_item.weight_q16 !== exp.weight_q16)
                    log_fault("result mismatch", exp, out_item);
            end
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        logic [7:0] addr_plan [5];
        i_rst_n       = 1'b0;
        in_valid      = 1'b0;
        in_item       = '0;
        out_stall     = 1'b0;
        cfg_valid     = 1'b0;
        cfg_data      = 8'h00;
        in_busy       = 1'b0;
        in_gap        = 0;
        stall_left    = 0;
        quiet_left[0] = 0;
        quiet_left[1] = 0;
        fault_count   = 0;
        addr_cfg      = SLAVE_ADDR_RESET;
        restart_frame();
        for (int i = 0; i < 4; i++) frame_data[i] = 8'h00;

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: timeout with nothing in progress, measurement extremes,
        // every decimal-point code and one above, distrusted byte count,
        // header faults, header and CRC both wrong, CRC fault, truncated frame.
        push_timeout();
        push_frame(SLAVE_ADDR_RESET, FUNC_READ_HOLDING, 8'd4, 16'h7FFF, 16'h0000, 16'h0, 9);
        push_frame(SLAVE_ADDR_RESET, FUNC_READ_HOLDING, 8'd4, 16'h8000, 16'h0001, 16'h0, 9);
        push_frame(SLAVE_ADDR_RESET, FUNC_READ_HOLDING, 8'd4, 16'hFFFF, 16'h0002, 16'h0, 9);
        push_frame(SLAVE_ADDR_RESET, FUNC_READ_HOLDING, 8'hFF, 16'h3039, 16'h0003, 16'h0, 9);
        push_frame(SLAVE_ADDR_RESET, FUNC_READ_HOLDING, 8'd0, 16'h8000, 16'h0003, 16'h0, 9);
        push_frame(SLAVE_ADDR_RESET, FUNC_READ_HOLDING, 8'd4, 16'h0001, 16'h0004, 16'h0, 9);
        push_frame(SLAVE_ADDR_RESET, FUNC_READ_HOLDING, 8'd4, 16'h7FFF, 16'hFFFF, 16'h0, 9);
        push_frame(8'h00, FUNC_READ_HOLDING, 8'd4, 16'h1234, 16'h0001, 16'h0, 9);
        push_frame(SLAVE_ADDR_RESET, 8'h04, 8'd4, 16'h1234, 16'h0001, 16'h0, 9);
        push_frame(8'hFF, 8'hFF, 8'd4, 16'h1234, 16'h0001, 16'h8001, 9);
        push_frame(SLAVE_ADDR_RESET, FUNC_READ_HOLDING, 8'd4, 16'h1234, 16'h0001, 16'h0100, 9);
        push_frame(SLAVE_ADDR_RESET, FUNC_READ_HOLDING, 8'd4, 16'h1234, 16'h0001, 16'h0, 5);
        push_timeout();
        wait_idle();

        // Random phases, first at the reset address, then through the extremes
        // and back to the reset value.
        addr_plan = '{8'h00, 8'hFF, 8'($urandom), 8'($urandom), SLAVE_ADDR_RESET};
        for (int p = 0; p <= 5; p++) begin
            if (p > 0) cfg_write(addr_plan[p - 1]);
            repeat (PhaseFrames) random_frame();
            push_timeout();    // leaves the frame state clean before the next write
            wait_idle();
        end

        while (result_queue.size() > 0) log_fault("missing result", result_queue.pop_front(), '0);

        if (fault_count == 0) $display("Verification passed");
        else                  $display("Verification failed");
        $finish;
    end

    // Watchdog
    initial begin
        #10_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule
